// File: sv/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CONSUMED_W = 17;
    localparam int ERR_W      = 3;
    localparam int PHASE_W    = 4;

    localparam logic [PHASE_W-1:0] PH_FIRST_DIGIT   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE          = 4'd1;
    localparam logic [PHASE_W-1:0] PH_EXT           = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SIZE_LF       = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DATA          = 4'd4;
    localparam logic [PHASE_W-1:0] PH_DATA_CR       = 4'd5;
    localparam logic [PHASE_W-1:0] PH_DATA_LF       = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TRAILER_START = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TRAILER       = 4'd8;
    localparam logic [PHASE_W-1:0] PH_TRAILER_LF    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_END_LF        = 4'd10;
    localparam logic [PHASE_W-1:0] PH_DONE          = 4'd11;

    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NON_HEX    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SIZE_LF    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DATA_CR    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_DATA_LF    = 3'd5;
    localparam logic [ERR_W-1:0] ERR_TRAILER_LF = 3'd6;
    localparam logic [ERR_W-1:0] ERR_END_LF     = 3'd7;

    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     payload_byte;
        logic                  payload_valid;
        logic                  consumed;
        logic                  complete;
        logic [ERR_W-1:0]      error_code;
        logic [CONSUMED_W-1:0] buffer_consumed;
    } hcbd_result_t;

    function automatic hex_digit_t hex_value(input logic [BYTE_W-1:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.val = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// File: sv/hcbd_core.sv
`default_nettype none
module hcbd_core #(
    parameter int SIZE_WIDTH = 63,
    parameter int MAX_BUFFER = 65536
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       step_en,
    input  wire [hcbd_pkg::BYTE_W-1:0] in_byte,
    input  wire                       in_last,
    output hcbd_pkg::hcbd_result_t    result
);
    import hcbd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BUFFER + 1);

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [SIZE_WIDTH-1:0] size_reg, size_next;
    logic [SIZE_WIDTH-1:0] left_reg, left_next;
    logic [ERR_W-1:0]      error_reg, error_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    hex_digit_t            hd;
    logic [ERR_W-1:0]      err;
    logic                  used;
    logic                  valid;
    logic [SIZE_WIDTH-1:0] left_dec;
    logic [CNT_W-1:0]      count_inc;

    always_comb begin
        hd         = hex_value(in_byte);
        err        = ERR_NONE;
        used       = 1'b0;
        valid      = 1'b0;
        phase_next = phase_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        left_dec   = left_reg;
        if (error_reg == ERR_NONE && phase_reg != PH_DONE) begin
            used = 1'b1;
            unique case (phase_reg)
                PH_FIRST_DIGIT: begin
                    if (hd.ok) begin
                        size_next  = SIZE_WIDTH'(hd.val);
                        phase_next = PH_SIZE;
                    end else begin
                        err = ERR_NON_HEX;
                    end
                end
                PH_SIZE: begin
                    if (hd.ok) begin
                        if (size_reg[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                            err = ERR_OVERFLOW;
                        end else begin
                            size_next = {size_reg[SIZE_WIDTH-5:0], 4'd0}
                                      + SIZE_WIDTH'(hd.val);
                        end
                    end else if (in_byte == CH_SEMI) begin
                        phase_next = PH_EXT;
                    end else if (in_byte == CH_CR) begin
                        phase_next = PH_SIZE_LF;
                    end else begin
                        err = ERR_NON_HEX;
                    end
                end
                PH_EXT: begin
                    if (in_byte == CH_CR) phase_next = PH_SIZE_LF;
                end
                PH_SIZE_LF: begin
                    if (in_byte == CH_LF) begin
                        left_next  = size_reg;
                        phase_next = (size_reg == '0) ? PH_TRAILER_START : PH_DATA;
                    end else begin
                        err = ERR_SIZE_LF;
                    end
                end
                PH_DATA: begin
                    valid = 1'b1;
                    if (left_reg != '0) left_dec = left_reg - SIZE_WIDTH'(1);
                    left_next = left_dec;
                    if (left_dec == '0) phase_next = PH_DATA_CR;
                end
                PH_DATA_CR: begin
                    if (in_byte == CH_CR) phase_next = PH_DATA_LF;
                    else err = ERR_DATA_CR;
                end
                PH_DATA_LF: begin
                    if (in_byte == CH_LF) begin
                        if (size_reg == '0) begin
                            phase_next = PH_TRAILER_START;
                        end else begin
                            size_next  = '0;
                            left_next  = '0;
                            phase_next = PH_FIRST_DIGIT;
                        end
                    end else begin
                        err = ERR_DATA_LF;
                    end
                end
                PH_TRAILER_START: begin
                    phase_next = (in_byte == CH_CR) ? PH_END_LF : PH_TRAILER;
                end
                PH_TRAILER: begin
                    if (in_byte == CH_CR) phase_next = PH_TRAILER_LF;
                end
                PH_TRAILER_LF: begin
                    if (in_byte == CH_LF) phase_next = PH_TRAILER_START;
                    else err = ERR_TRAILER_LF;
                end
                PH_END_LF: begin
                    if (in_byte == CH_LF) phase_next = PH_DONE;
                    else err = ERR_END_LF;
                end
                default: begin
                    err = ERR_NON_HEX;
                end
            endcase
            if (err != ERR_NONE) begin
                used       = 1'b0;
                valid      = 1'b0;
                phase_next = phase_reg;
                size_next  = size_reg;
                left_next  = left_reg;
            end
        end
        error_next = (err != ERR_NONE) ? err : error_reg;

        count_inc = count_reg;
        if (used && count_reg < CNT_W'(MAX_BUFFER)) count_inc = count_reg + CNT_W'(1);
        count_next = in_last ? '0 : count_inc;

        result.payload_byte    = valid ? in_byte : '0;
        result.payload_valid   = valid;
        result.consumed        = used;
        result.complete        = (error_next == ERR_NONE) && (phase_next == PH_DONE);
        result.error_code      = error_next;
        result.buffer_consumed = in_last ? CONSUMED_W'(count_inc) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST_DIGIT;
            size_reg  <= '0;
            left_reg  <= '0;
            error_reg <= ERR_NONE;
            count_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
            error_reg <= error_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/http_chunked_body_decoder.sv
// accepted bytes pass the input register, the parse step, then the result register
// throughput: one item per cycle unless m_ready stalls the output; the parse step
// is combinational; a stalled result register holds one item, the input register the next
// reset (aresetn low, synchronous): parse phase back to first size digit, sizes, error
// and buffer count cleared, both pipeline registers emptied
`default_nettype none
module http_chunked_body_decoder #(
    parameter int SIZE_WIDTH = 63,
    parameter int MAX_BUFFER = 65536
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [hcbd_pkg::BYTE_W-1:0]      s_in_byte,
    input  wire                              s_buffer_last,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [hcbd_pkg::BYTE_W-1:0]      m_payload_byte,
    output logic                             m_payload_valid,
    output logic                             m_consumed,
    output logic                             m_complete,
    output logic [hcbd_pkg::ERR_W-1:0]       m_error_code,
    output logic [hcbd_pkg::CONSUMED_W-1:0]  m_buffer_consumed
);
    import hcbd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    hcbd_result_t      out_reg;
    hcbd_result_t      step_result;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    hcbd_core #(
        .SIZE_WIDTH(SIZE_WIDTH),
        .MAX_BUFFER(MAX_BUFFER)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_buffer_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_reg       <= step_result;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_payload_byte    = out_reg.payload_byte;
    assign m_payload_valid   = out_reg.payload_valid;
    assign m_consumed        = out_reg.consumed;
    assign m_complete        = out_reg.complete;
    assign m_error_code      = out_reg.error_code;
    assign m_buffer_consumed = out_reg.buffer_consumed;

    // payload only on consumed items
    a_payload_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid |-> m_consumed)
        else $error("payload item not marked consumed");

    // completion never shown together with an error
    a_complete_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_complete |-> m_error_code == ERR_NONE)
        else $error("complete with error");

    // error code is sticky
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && ($past(m_error_code) != ERR_NONE)
        |-> m_error_code == $past(m_error_code))
        else $error("error code changed after an error");

    // a waiting input item moves on whenever the result register is free
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !m_valid |=> m_valid)
        else $error("input item stalled with empty result register");

endmodule
`default_nettype wire
